>>> rtl/core/lzf_stream_decompressor_defines.svh
// Assertion macros for the LZF stream decompressor.
`ifndef LZF_STREAM_DECOMPRESSOR_DEFINES_SVH
`define LZF_STREAM_DECOMPRESSOR_DEFINES_SVH

`ifndef SYNTHESIS
`define LZF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzf assertion failed");
`define LZF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzf assertion failed");
`else
`define LZF_ASSERT_IMP(lbl, ante, cons)
`define LZF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/lzf_pkg.sv
// Shared types and constants of the LZF stream decompressor.
`timescale 1ns / 1ps
`default_nettype none

package lzf_pkg;

  localparam int WORD_W = 64;
  localparam int CNT_W  = 4;
  localparam int LEN_W  = 32;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_TRUNC = 3'd1,
    ERR_OVF   = 3'd2,
    ERR_REF   = 3'd3,
    ERR_LEN   = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_LIT  = 2'd1,
    PH_EXT  = 2'd2,
    PH_OFS  = 2'd3
  } phase_t;

  typedef struct packed {
    logic stream_done;
    err_t status;
  } lzf_meta_t;

endpackage

`default_nettype wire

>>> rtl/core/lzf_stream_decompressor.sv
// Top level of the LZF stream decompressor: token sequencer and history.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid / in_ready  | in_byte, in_last
//  out     | out | out_valid / out_ready| out_data, out_count, out_run_last,
//          |     |                      | out_stream_done, out_status
//  cfg     | in  | cfg_valid / cfg_ready| cfg_data (expected length)
//
// Control, extension and literal bytes pass through S_IDLE and S_DECODE, then
// S_FLUSH or, for a literal, S_EMIT. A back reference offset byte goes on to
// S_CHECK, then S_RD and S_WR per copied byte: history RAM read and write-back.
// Reset is synchronous, active low; no clearing pass, history is undefined.
// A held output word stalls the sequencer on every byte push and flush until taken.
`timescale 1ns / 1ps
`default_nettype none
`include "lzf_stream_decompressor_defines.svh"

module lzf_stream_decompressor #(
  parameter int HISTORY_BYTES      = 8192,
  parameter int OUT_BYTES_PER_WORD = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_data,
  output logic [3:0]       out_count,
  output logic             out_run_last,
  output logic             out_stream_done,
  output logic [2:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  localparam int AW = $clog2(HISTORY_BYTES);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_RD     = 7'b0001000,
    S_WR     = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_FLUSH  = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  lzf_pkg::phase_t      phase_r, phase_nxt;
  lzf_pkg::err_t        err_r, err_nxt;
  logic [4:0]           lit_left_r, lit_left_nxt;
  logic [8:0]           len_r, len_nxt;
  logic [4:0]           off_hi_r, off_hi_nxt;
  logic [31:0]          bw_r, bw_nxt;
  logic [31:0]          exp_r;
  logic [AW-1:0]        wp_r, wp_nxt;
  logic [AW-1:0]        src_r, src_nxt;
  logic [8:0]           copy_left_r, copy_left_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 last_r, last_nxt;

  logic [13:0]          back_dist;
  logic [AW:0]          diff;
  logic [31:0]          alu_a, alu_b, alu_c;
  logic                 alu_gt, alu_ne;
  logic                 pk_push, pk_final, pk_ok;
  logic [7:0]           pk_byte;
  lzf_pkg::lzf_meta_t   pk_meta;
  logic                 ram_we, ram_re;
  logic [7:0]           ram_rdata;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  always_comb begin
    back_dist = {1'b0, off_hi_r, byte_r} + 14'd1;
    diff      = {1'b0, wp_r} - (AW+1)'(back_dist);
    alu_a     = bw_r;
    alu_b     = 32'd0;
    alu_c     = exp_r;
    if (state_r == S_CHECK) begin
      alu_b = {23'd0, len_r};
    end else begin
      case (phase_r)
        lzf_pkg::PH_CTRL: alu_b = {24'd0, byte_r} + 32'd1;
        lzf_pkg::PH_LIT:  alu_b = 32'd1;
        lzf_pkg::PH_OFS: begin
          alu_a = {18'd0, back_dist};
          alu_c = bw_r;
        end
        default: alu_b = 32'd0;
      endcase
    end
  end

  lzf_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .c  (alu_c),
    .gt (alu_gt),
    .ne (alu_ne)
  );

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    err_nxt       = err_r;
    lit_left_nxt  = lit_left_r;
    len_nxt       = len_r;
    off_hi_nxt    = off_hi_r;
    bw_nxt        = bw_r;
    wp_nxt        = wp_r;
    src_nxt       = src_r;
    copy_left_nxt = copy_left_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    pk_push       = 1'b0;
    pk_final      = 1'b0;
    pk_byte       = byte_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt  = in_byte;
          last_nxt  = in_last;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FLUSH;
        if (err_r == lzf_pkg::ERR_NONE) begin
          unique case (phase_r)
            lzf_pkg::PH_CTRL: begin
              if (byte_r[7:5] == 3'd0) begin
                lit_left_nxt = byte_r[4:0];
                if (last_r) err_nxt = lzf_pkg::ERR_TRUNC;
                else if (alu_gt) err_nxt = lzf_pkg::ERR_OVF;
                else phase_nxt = lzf_pkg::PH_LIT;
              end else begin
                off_hi_nxt = byte_r[4:0];
                if (last_r) begin
                  err_nxt = lzf_pkg::ERR_TRUNC;
                end else if (byte_r[7:5] == 3'd7) begin
                  len_nxt   = 9'd7;
                  phase_nxt = lzf_pkg::PH_EXT;
                end else begin
                  len_nxt   = {6'd0, byte_r[7:5]} + 9'd2;
                  phase_nxt = lzf_pkg::PH_OFS;
                end
              end
            end
            lzf_pkg::PH_LIT: begin
              state_nxt = S_EMIT;
              if (lit_left_r == 5'd0) begin
                phase_nxt = lzf_pkg::PH_CTRL;
                if (last_r && alu_ne) err_nxt = lzf_pkg::ERR_LEN;
              end else begin
                lit_left_nxt = lit_left_r - 5'd1;
                if (last_r) err_nxt = lzf_pkg::ERR_TRUNC;
              end
            end
            lzf_pkg::PH_EXT: begin
              len_nxt = {1'b0, byte_r} + 9'd9;
              if (last_r) err_nxt = lzf_pkg::ERR_TRUNC;
              else phase_nxt = lzf_pkg::PH_OFS;
            end
            lzf_pkg::PH_OFS: begin
              phase_nxt = lzf_pkg::PH_CTRL;
              if (alu_gt) err_nxt = lzf_pkg::ERR_REF;
              else state_nxt = S_CHECK;
            end
            default: state_nxt = S_FLUSH;
          endcase
        end
      end
      S_CHECK: begin
        copy_left_nxt = len_r;
        src_nxt = diff[AW] ? diff[AW-1:0] + AW'(HISTORY_BYTES) : diff[AW-1:0];
        if (alu_gt) begin
          err_nxt   = lzf_pkg::ERR_OVF;
          state_nxt = S_FLUSH;
        end else begin
          if (last_r && alu_ne) err_nxt = lzf_pkg::ERR_LEN;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        pk_push  = 1'b1;
        pk_final = (copy_left_r == 9'd1);
        pk_byte  = ram_rdata;
        if (pk_ok) begin
          ram_we        = 1'b1;
          bw_nxt        = bw_r + 32'd1;
          wp_nxt        = (wp_r == AW'(HISTORY_BYTES - 1)) ? '0 : wp_r + AW'(1);
          src_nxt       = (src_r == AW'(HISTORY_BYTES - 1)) ? '0 : src_r + AW'(1);
          copy_left_nxt = copy_left_r - 9'd1;
          state_nxt     = pk_final ? S_IDLE : S_RD;
        end
      end
      S_EMIT: begin
        pk_push  = 1'b1;
        pk_final = 1'b1;
        if (pk_ok) begin
          ram_we    = 1'b1;
          bw_nxt    = bw_r + 32'd1;
          wp_nxt    = (wp_r == AW'(HISTORY_BYTES - 1)) ? '0 : wp_r + AW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        pk_final = 1'b1;
        if (pk_ok) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // end of stream: back to a fresh stream
    if (state_r != S_IDLE && state_nxt == S_IDLE && last_r) begin
      bw_nxt       = 32'd0;
      wp_nxt       = '0;
      phase_nxt    = lzf_pkg::PH_CTRL;
      lit_left_nxt = 5'd0;
      len_nxt      = 9'd0;
      off_hi_nxt   = 5'd0;
      err_nxt      = lzf_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      phase_r    <= lzf_pkg::PH_CTRL;
      err_r      <= lzf_pkg::ERR_NONE;
      lit_left_r <= 5'd0;
      len_r      <= 9'd0;
      off_hi_r   <= 5'd0;
      bw_r       <= 32'd0;
      wp_r       <= '0;
      exp_r      <= 32'd0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      err_r      <= err_nxt;
      lit_left_r <= lit_left_nxt;
      len_r      <= len_nxt;
      off_hi_r   <= off_hi_nxt;
      bw_r       <= bw_nxt;
      wp_r       <= wp_nxt;
      if (cfg_valid && cfg_ready) begin
        exp_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    last_r      <= last_nxt;
    src_r       <= src_nxt;
    copy_left_r <= copy_left_nxt;
  end

  lzf_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_BYTES)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (pk_byte),
    .re    (ram_re),
    .raddr (src_r),
    .rdata (ram_rdata)
  );

  assign pk_meta.stream_done = last_r;
  assign pk_meta.status      = err_r;

  lzf_pack #(
    .OUT_BYTES_PER_WORD (OUT_BYTES_PER_WORD)
  ) u_pack (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (pk_push),
    .final_word      (pk_final),
    .byte_in         (pk_byte),
    .meta            (pk_meta),
    .ok              (pk_ok),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .out_count       (out_count),
    .out_run_last    (out_run_last),
    .out_stream_done (out_stream_done),
    .out_status      (out_status)
  );

  `LZF_ASSERT_IMP(a_count_max, out_valid, out_count <= 4'(OUT_BYTES_PER_WORD))
  `LZF_ASSERT_IMP(a_status_only_last, out_valid && out_count == 4'd0, out_run_last)
  `LZF_ASSERT_NXT(a_copy_loop, state_r == S_WR && pk_ok && copy_left_r != 9'd1,
                  state_r == S_RD)
  `LZF_ASSERT_NXT(a_stream_clear, state_r != S_IDLE && state_nxt == S_IDLE && last_r,
                  bw_r == 32'd0 && err_r == lzf_pkg::ERR_NONE)

endmodule

`default_nettype wire

>>> rtl/core/lzf_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module lzf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/core/lzf_alu.sv
// Shared add-and-compare unit: (a + b) against c.
`timescale 1ns / 1ps
`default_nettype none

module lzf_alu (
  input  wire logic [lzf_pkg::LEN_W-1:0] a,
  input  wire logic [lzf_pkg::LEN_W-1:0] b,
  input  wire logic [lzf_pkg::LEN_W-1:0] c,
  output logic                           gt,
  output logic                           ne
);

  logic [lzf_pkg::LEN_W:0] sum;

  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    gt  = sum > {1'b0, c};
    ne  = sum != {1'b0, c};
  end

endmodule

`default_nettype wire

>>> rtl/core/lzf_pack.sv
// Byte packer and output word register.
`timescale 1ns / 1ps
`default_nettype none

module lzf_pack #(
  parameter int OUT_BYTES_PER_WORD = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  input  wire logic                            final_word,
  input  wire logic [7:0]                      byte_in,
  input  wire lzf_pkg::lzf_meta_t              meta,
  output logic                                 ok,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [lzf_pkg::WORD_W-1:0]      out_data,
  output logic      [lzf_pkg::CNT_W-1:0]       out_count,
  output logic                                 out_run_last,
  output logic                                 out_stream_done,
  output logic      [2:0]                      out_status
);

  logic [lzf_pkg::WORD_W-1:0] acc_r;
  logic [lzf_pkg::CNT_W-1:0]  cnt_r;
  logic                       ov_r;
  logic [lzf_pkg::WORD_W-1:0] data_r;
  logic [lzf_pkg::CNT_W-1:0]  count_r;
  logic                       run_last_r;
  logic                       done_r;
  lzf_pkg::err_t              status_r;

  logic [lzf_pkg::WORD_W-1:0] sh_byte;
  logic [lzf_pkg::WORD_W-1:0] word_data;
  logic [lzf_pkg::CNT_W-1:0]  word_count;
  logic                       emit;

  always_comb begin
    ok         = !ov_r || out_ready;
    sh_byte    = {56'd0, byte_in} << {cnt_r[2:0], 3'b000};
    word_data  = acc_r | (push ? sh_byte : '0);
    word_count = cnt_r + {{(lzf_pkg::CNT_W-1){1'b0}}, push};
    emit       = ok && (final_word ||
                 (push && cnt_r == lzf_pkg::CNT_W'(OUT_BYTES_PER_WORD - 1)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else if (emit) begin
      acc_r <= '0;
      cnt_r <= '0;
      ov_r  <= 1'b1;
    end else begin
      if (ok && push) begin
        acc_r <= word_data;
        cnt_r <= word_count;
      end
      if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      data_r     <= word_data;
      count_r    <= word_count;
      run_last_r <= final_word;
      done_r     <= meta.stream_done;
      status_r   <= meta.status;
    end
  end

  assign out_valid       = ov_r;
  assign out_data        = data_r;
  assign out_count       = count_r;
  assign out_run_last    = run_last_r;
  assign out_stream_done = done_r;
  assign out_status      = status_r;

endmodule

`default_nettype wire

>>> sim/tb_lzf_stream_decompressor.sv
// Self-checking testbench for lzf_stream_decompressor: directed and random LZF streams.
`timescale 1ns / 1ps

module tb_lzf_stream_decompressor;

  localparam int HIST_BYTES    = 8192;
  localparam int HIST_AW       = $clog2(HIST_BYTES);
  localparam int WORD_BYTES    = 8;
  localparam int RANDOM_ITEMS  = 250;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 5000000;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } comp_byte_t;

  typedef struct {
    logic [63:0]   data;
    logic [3:0]    count;
    logic          run_last;
    logic          done;
    lzf_pkg::err_t status;
  } decoded_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_data;
  logic [3:0]  out_count;
  logic        out_run_last;
  logic        out_stream_done;
  logic [2:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  lzf_stream_decompressor uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .out_count       (out_count),
    .out_run_last    (out_run_last),
    .out_stream_done (out_stream_done),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  comp_byte_t    comp_bytes_q[$];
  decoded_word_t decoded_q[$];
  decoded_word_t burst[$];
  logic [7:0]    sbuf[$];

  comp_byte_t tx_item;
  logic       in_fire_q = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;
  bit         tx_gaps_on = 1'b1;
  bit         rx_stall_on = 1'b1;
  int         err_cnt = 0;
  int         items_queued = 0;
  int         cycle_cnt = 0;

  // decoder state
  logic [7:0]       hist_mem [0:HIST_BYTES-1];
  longint unsigned  dec_written = 0;
  lzf_pkg::phase_t  dec_phase = lzf_pkg::PH_CTRL;
  logic [4:0]       dec_lit_left = '0;
  int unsigned      dec_copy_len = 0;
  logic [4:0]       dec_ofs_high = '0;
  lzf_pkg::err_t    dec_err = lzf_pkg::ERR_NONE;
  longint unsigned  dec_exp_len = 0;
  logic [63:0]      pack_acc = '0;
  int               pack_cnt = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic flush_pack();
    decoded_word_t w;
    if (pack_cnt != 0) begin
      w.data = pack_acc;
      w.count = pack_cnt[3:0];
      burst.insert(burst.size(), w);
      pack_acc = '0;
      pack_cnt = 0;
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    hist_mem[HIST_AW'(dec_written % HIST_BYTES)] = b;
    dec_written++;
    pack_acc[8*pack_cnt +: 8] = b;
    pack_cnt++;
    if (pack_cnt == WORD_BYTES) flush_pack();
  endtask

  task automatic decode_step(input logic [7:0] b, input logic last);
    longint unsigned copy_dist;
    decoded_word_t   w;
    int unsigned     k;
    burst.delete();
    pack_acc = '0;
    pack_cnt = 0;
    if (dec_err == lzf_pkg::ERR_NONE) begin
      case (dec_phase)
        lzf_pkg::PH_CTRL: begin
          if (b < 8'd32) begin
            dec_lit_left = b[4:0];
            if (last) dec_err = lzf_pkg::ERR_TRUNC;
            else if (dec_written + b + 1 > dec_exp_len) dec_err = lzf_pkg::ERR_OVF;
            else dec_phase = lzf_pkg::PH_LIT;
          end else begin
            dec_ofs_high = b[4:0];
            if (last) begin
              dec_err = lzf_pkg::ERR_TRUNC;
            end else if (b[7:5] == 3'd7) begin
              dec_copy_len = 7;
              dec_phase = lzf_pkg::PH_EXT;
            end else begin
              dec_copy_len = b[7:5] + 2;
              dec_phase = lzf_pkg::PH_OFS;
            end
          end
        end
        lzf_pkg::PH_LIT: begin
          put_byte(b);
          if (dec_lit_left == 0) begin
            dec_phase = lzf_pkg::PH_CTRL;
          end else begin
            dec_lit_left--;
            if (last) dec_err = lzf_pkg::ERR_TRUNC;
          end
        end
        lzf_pkg::PH_EXT: begin
          dec_copy_len = 9 + b;
          if (last) dec_err = lzf_pkg::ERR_TRUNC;
          else dec_phase = lzf_pkg::PH_OFS;
        end
        default: begin
          copy_dist = 64'({dec_ofs_high, b}) + 64'd1;
          if (copy_dist > dec_written) begin
            dec_err = lzf_pkg::ERR_REF;
          end else if (dec_written + dec_copy_len > dec_exp_len) begin
            dec_err = lzf_pkg::ERR_OVF;
          end else begin
            for (k = 0; k < dec_copy_len; k++)
              put_byte(hist_mem[HIST_AW'((dec_written - copy_dist) % HIST_BYTES)]);
          end
          dec_phase = lzf_pkg::PH_CTRL;
        end
      endcase
      if (last && dec_err == lzf_pkg::ERR_NONE && dec_written != dec_exp_len)
        dec_err = lzf_pkg::ERR_LEN;
    end
    flush_pack();
    if (burst.size() == 0) begin
      w.data = '0;
      w.count = '0;
      burst.insert(burst.size(), w);
    end
    for (k = 0; k < burst.size(); k++) begin
      w = burst[k];
      w.run_last = (k == burst.size() - 1);
      w.done = last;
      w.status = dec_err;
      decoded_q.insert(decoded_q.size(), w);
    end
    if (last) begin
      dec_written = 0;
      dec_phase = lzf_pkg::PH_CTRL;
      dec_lit_left = '0;
      dec_copy_len = 0;
      dec_ofs_high = '0;
      dec_err = lzf_pkg::ERR_NONE;
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      err_cnt++;
    end
  endtask

  // input/config capture, prediction and output checking
  always @(posedge clk) begin
    decoded_word_t w;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) dec_exp_len = 64'(cfg_data);
      if (in_valid && in_ready) decode_step(in_byte, in_last);
      in_fire_q <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got data %h count %0d status %0d",
                   $time, out_data, out_count, out_status);
          err_cnt++;
        end else begin
          w = decoded_q.pop_front();
          check_field("out_data", out_data, w.data);
          check_field("out_count", out_count, w.count);
          check_field("out_run_last", out_run_last, w.run_last);
          check_field("out_stream_done", out_stream_done, w.done);
          check_field("out_status", out_status, w.status);
        end
      end
    end else begin
      in_fire_q <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire_q) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (comp_bytes_q.size() != 0) begin
        tx_item = comp_bytes_q.pop_front();
        in_valid <= 1'b1;
        in_byte <= tx_item.b;
        in_last <= tx_item.last;
        gap_left <= tx_gaps_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (!rx_stall_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, decoded_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_item(input logic [7:0] b, input logic last);
    comp_byte_t c;
    c.b = b;
    c.last = last;
    comp_bytes_q.insert(comp_bytes_q.size(), c);
    items_queued++;
  endtask

  task automatic queue_stream(input int last_idx);
    int i;
    for (i = 0; i <= last_idx; i++) push_item(sbuf[i], i == last_idx);
  endtask

  task automatic wait_drained();
    while (comp_bytes_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [31:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // build a stream producing exactly len bytes, well-formed unless bad_ref plants at most one out-of-range reference
  task automatic build_stream(input int unsigned len, input bit long_bias, input bit bad_ref);
    int unsigned made, rem, n, r, d, lim, lim_d, i;
    logic [12:0] dm1;
    logic [2:0]  fld;
    bit          did_bad;
    sbuf.delete();
    made = 0;
    did_bad = 1'b0;
    while (made < len) begin
      rem = len - made;
      if (made > 0 && rem >= 3 && $urandom_range(0, 99) < (long_bias ? 90 : 45)) begin
        lim = (rem > 264) ? 264 : rem;
        if (long_bias)
          n = ($urandom_range(0, 3) != 0) ? lim : $urandom_range(3, lim);
        else if ($urandom_range(0, 1) == 0)
          n = $urandom_range(3, (lim < 8) ? lim : 8);
        else
          n = $urandom_range(3, lim);
        lim_d = (made > HIST_BYTES) ? HIST_BYTES : made;
        if (bad_ref && !did_bad && made < HIST_BYTES) begin
          d = $urandom_range(made + 1, (made + 64 > HIST_BYTES) ? HIST_BYTES : made + 64);
          did_bad = 1'b1;
        end else if (long_bias && $urandom_range(0, 1) == 0) begin
          d = lim_d;
        end else if (!long_bias && $urandom_range(0, 9) < 7) begin
          d = $urandom_range(1, (lim_d < 16) ? lim_d : 16);
        end else begin
          d = $urandom_range(1, lim_d);
        end
        dm1 = 13'(d - 1);
        fld = (n <= 8) ? 3'(n - 2) : 3'd7;
        sbuf.insert(sbuf.size(), {fld, dm1[12:8]});
        if (n > 8) sbuf.insert(sbuf.size(), 8'(n - 9));
        sbuf.insert(sbuf.size(), dm1[7:0]);
        made += n;
      end else begin
        r = $urandom_range(1, (rem > 32) ? 32 : rem);
        sbuf.insert(sbuf.size(), 8'(r - 1));
        for (i = 0; i < r; i++) sbuf.insert(sbuf.size(), 8'($urandom_range(0, 255)));
        made += r;
      end
    end
  endtask

  initial begin
    int unsigned len, len2;
    int phase_no, nstreams, s, kind, cut, i;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // no output allowed: truncation, overflow, bad references
    write_length(32'd0);
    push_item(8'h00, 1'b1);
    push_item(8'h1f, 1'b0);
    push_item(8'hff, 1'b1);
    push_item(8'h20, 1'b0);
    push_item(8'h00, 1'b1);
    push_item(8'hff, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hff, 1'b1);

    // longest copies, exact fit and copy overflow
    write_length(32'd266);
    push_item(8'h01, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hff, 1'b0);
    push_item(8'he0, 1'b0);
    push_item(8'hff, 1'b0);
    push_item(8'h01, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h11, 1'b0);
    push_item(8'he0, 1'b0);
    push_item(8'hff, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h20, 1'b0);
    push_item(8'h00, 1'b1);

    // mid-literal truncation and length mismatch
    write_length(32'hffff_ffff);
    push_item(8'h02, 1'b0);
    push_item(8'h11, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h42, 1'b1);

    items_queued = 0;
    phase_no = 0;
    while (items_queued < RANDOM_ITEMS) begin
      if (phase_no == 2) len = 8300;
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(200, 600);
      else len = $urandom_range(1, 60);
      write_length(len);
      tx_gaps_on = (phase_no == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      if (phase_no == 1) hold_req = 1'b1;
      nstreams = (phase_no == 2) ? 1 : $urandom_range(2, 5);
      for (s = 0; s < nstreams; s++) begin
        kind = (phase_no == 2) ? 0 : $urandom_range(0, 99);
        if (kind < 65) begin
          build_stream(len, phase_no == 2, 1'b0);
          queue_stream(sbuf.size() - 1);
        end else if (kind < 77) begin
          build_stream(len, 1'b0, 1'b0);
          cut = (sbuf.size() >= 2) ? $urandom_range(0, sbuf.size() - 2) : 0;
          queue_stream(cut);
        end else if (kind < 85) begin
          len2 = $urandom_range(1, len + 40);
          build_stream(len2, 1'b0, 1'b0);
          queue_stream(sbuf.size() - 1);
        end else if (kind < 93) begin
          build_stream(len, 1'b0, 1'b1);
          queue_stream(sbuf.size() - 1);
        end else begin
          sbuf.delete();
          cut = $urandom_range(1, 6);
          for (i = 0; i < cut; i++) sbuf.insert(sbuf.size(), 8'($urandom_range(0, 255)));
          queue_stream(cut - 1);
        end
      end
      phase_no++;
    end

    wait_drained();
    if (err_cnt == 0 && decoded_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
